@@ hdl/ipc_pkg.sv @@
// shared constants, types and coefficient selection for the iteration palette colorizer
package ipc_pkg;

  localparam int CNT_W = 16;

  // register map indexes
  localparam logic [1:0] REG_PALETTE = 2'd0;
  localparam logic [1:0] REG_ANIMATE = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;
  localparam logic [1:0] REG_FRAME_TIME = 2'd3;

  // palette codes, code 3 falls back to classic
  localparam logic [1:0] PAL_CLASSIC = 2'd0;
  localparam logic [1:0] PAL_BLUE = 2'd1;
  localparam logic [1:0] PAL_FIRE = 2'd2;

  // frequencies in turns, unsigned q2.32
  localparam logic [33:0] CF4 = 34'd2734261102;
  localparam logic [33:0] CF5 = 34'd3417826378;
  localparam logic [33:0] CF6 = 34'd4101391653;
  localparam logic [33:0] CF8 = 34'd5468522205;
  localparam logic [33:0] CF12 = 34'd8202783307;
  localparam logic [33:0] CF16 = 34'd10937044409;
  // phase offsets in turns, q0.32
  localparam logic [31:0] OFS1 = 32'd683565276;
  localparam logic [31:0] OFS2 = 32'd1367130551;
  // animation rates in turns per second, q0.32
  localparam logic [31:0] CR_CLASSIC = 32'd205069583;
  localparam logic [31:0] CR_BLUE_R = 32'd136713055;
  localparam logic [31:0] CR_BLUE_G = 32'd191398277;
  localparam logic [31:0] CR_BLUE_B = 32'd273426110;
  localparam logic [31:0] CR_FIRE_G = 32'd410139165;
  localparam logic [31:0] CR_FIRE_B = 32'd533180915;

  localparam logic [7:0] FIRE_G_GAIN = 8'd150;
  localparam logic [7:0] FIRE_B_GAIN = 8'd100;
  localparam logic [7:0] CHAN_FULL = 8'hFF;

  typedef struct packed {
    logic [33:0] cf;
    logic [31:0] ofs;
    logic [31:0] cr;
    logic [7:0]  base;
    logic [7:0]  amp;
  } chan_coef_t;

  function automatic chan_coef_t coef_sel(input logic [1:0] pal, input logic [1:0] ch);
    chan_coef_t c;
    c = '0;
    case (pal)
      PAL_BLUE: begin
        case (ch)
          2'd0:    c = '{cf: CF4, ofs: 32'd0, cr: CR_BLUE_R, base: 8'd80, amp: 8'd60};
          2'd1:    c = '{cf: CF6, ofs: OFS1, cr: CR_BLUE_G, base: 8'd120, amp: 8'd80};
          default: c = '{cf: CF8, ofs: OFS2, cr: CR_BLUE_B, base: 8'd220, amp: 8'd35};
        endcase
      end
      PAL_FIRE: begin
        case (ch)
          2'd1:    c = '{cf: CF12, ofs: 32'd0, cr: CR_FIRE_G, base: 8'd0, amp: 8'd0};
          2'd2:    c = '{cf: CF16, ofs: 32'd0, cr: CR_FIRE_B, base: 8'd0, amp: 8'd0};
          default: c = '0;
        endcase
      end
      default: begin
        if (ch == 2'd0) begin
          c = '{cf: CF5, ofs: 32'd0, cr: CR_CLASSIC, base: 8'd200, amp: 8'd55};
        end
      end
    endcase
    return c;
  endfunction

endpackage

@@ hdl/ipc_in_if.sv @@
// input word channel: one iteration count
interface ipc_in_if;
  import ipc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] iter_count;
  modport source (output valid, output iter_count, input ready);
  modport sink (input valid, input iter_count, output ready);
endinterface

// result word channel: one rgba pixel
interface ipc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

@@ hdl/iteration_palette_colorizer_core.sv @@
// throughput: one word per cycle while the output is not stalled, set by a restoring divider
// of one quotient bit per stage followed by multiply, sine lookup (registered rom read) and
// channel stages
// a one-word skid in front accepts one more word while a finished pixel waits to be taken
// reset (rst_n low, synchronous) empties the pipeline and loads palette classic,
// animation off, max_iter 100 and frame_time 0
module iteration_palette_colorizer_core import ipc_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ipc_in_if.sink      in_if,
  ipc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F = FRAC_BITS;
  localparam int PL_W = F + 32;     // t times low word of the frequency
  localparam int PH_W = F + 2;      // t times top bits of the frequency
  localparam int SUM_W = F + 34;
  localparam int GM_W = F + 8;      // 150 * t
  localparam int BM_W = F + 7;      // 100 * t^2
  localparam int FG_W = GM_W + 18;
  localparam int FB_W = BM_W + 18;

  // ---------------- configuration registers ----------------
  logic [1:0]       palette_r;
  logic             animate_r;
  logic [CNT_W-1:0] max_iter_r;
  logic [31:0]      frame_time_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r    <= PAL_CLASSIC;
      animate_r    <= 1'b0;
      max_iter_r   <= 16'd100;
      frame_time_r <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PALETTE:    palette_r <= pwdata[1:0];
        REG_ANIMATE:    animate_r <= pwdata[0];
        REG_MAX_ITER:   max_iter_r <= pwdata[CNT_W-1:0];
        REG_FRAME_TIME: frame_time_r <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PALETTE:    prdata = {30'd0, palette_r};
      REG_ANIMATE:    prdata = {31'd0, animate_r};
      REG_MAX_ITER:   prdata = {16'd0, max_iter_r};
      REG_FRAME_TIME: prdata = frame_time_r;
      default:        prdata = 32'd0;
    endcase
  end

  // per-channel coefficients follow the palette register; the user must only change it
  // while the pipeline is empty, the block itself does not enforce this
  chan_coef_t coef [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) coef[c] = coef_sel(palette_r, 2'(c));
  end

  // animation phase per channel, free running from the registers; a write reaches it
  // through the configuration register and then the anim_r register
  logic [31:0] anim_r [0:2];
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      anim_r[c] <= animate_r ? 32'((64'(frame_time_r) * 64'(coef[c].cr)) >> 16) : 32'd0;
    end
  end

  // ---------------- input skid and pipeline enable ----------------
  logic             pipe_en;
  logic             out_vld_r;
  logic             skid_vld_r;
  logic [CNT_W-1:0] skid_cnt_r;
  logic             in_acc;

  assign pipe_en = !out_vld_r || out_if.ready;
  assign in_if.ready = !skid_vld_r;
  assign in_acc = in_if.valid && !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r && pipe_en) begin
      skid_vld_r <= 1'b0;
    end else if (in_acc && !pipe_en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !pipe_en) skid_cnt_r <= in_if.iter_count;
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [CNT_W:0]   entry_cnt;
  logic             vld_d_r [0:F];
  logic             blk_d_r [0:F];
  logic [CNT_W-1:0] rem_r [0:F];
  logic [F-1:0]     quo_r [0:F];

  assign entry_cnt = skid_vld_r ? {1'b1, skid_cnt_r} : {in_acc, in_if.iter_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r[0] <= 1'b0;
    end else if (pipe_en) begin
      vld_d_r[0] <= entry_cnt[CNT_W];
    end
  end

  // a count at or above the limit (or a zero limit) is black
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rem_r[0]   <= entry_cnt[CNT_W-1:0];
      quo_r[0]   <= '0;
      blk_d_r[0] <= entry_cnt[CNT_W-1:0] >= max_iter_r;
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_div
    logic [CNT_W:0] dbl;
    logic           fits;
    always_comb begin
      dbl  = {rem_r[i-1], 1'b0};
      fits = dbl >= {1'b0, max_iter_r};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_d_r[i] <= 1'b0;
      end else if (pipe_en) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rem_r[i]   <= fits ? CNT_W'(dbl - {1'b0, max_iter_r}) : CNT_W'(dbl);
        quo_r[i]   <= {quo_r[i-1][F-2:0], fits};
        blk_d_r[i] <= blk_d_r[i-1];
      end
    end
  end

  // ---------------- stage a: products of t ----------------
  logic [F-1:0]    t_val;
  logic            vld_a_r;
  logic            blk_a_r;
  logic [PL_W-1:0] pl_r [0:2];
  logic [PH_W-1:0] ph_r [0:2];
  logic [2*F-1:0]  tt_r;
  logic [GM_W-1:0] gm_a_r;

  assign t_val = quo_r[F];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_a_r <= 1'b0;
    else if (pipe_en) vld_a_r <= vld_d_r[F];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blk_a_r <= blk_d_r[F];
      for (int c = 0; c < 3; c++) begin
        pl_r[c] <= PL_W'(t_val) * PL_W'(coef[c].cf[31:0]);
        ph_r[c] <= PH_W'(t_val) * PH_W'(coef[c].cf[33:32]);
      end
      tt_r   <= (2*F)'(t_val) * (2*F)'(t_val);
      gm_a_r <= GM_W'(t_val) * GM_W'(FIRE_G_GAIN);
    end
  end

  // ---------------- stage b: sine phases in turns ----------------
  logic [SUM_W-1:0] fsum [0:2];
  logic             vld_b_r;
  logic             blk_b_r;
  logic [31:0]      phase_b_r [0:2];
  logic [F-1:0]     t2_b_r;
  logic [GM_W-1:0]  gm_b_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fsum[c] = SUM_W'(pl_r[c]) + {ph_r[c], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_b_r <= 1'b0;
    else if (pipe_en) vld_b_r <= vld_a_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blk_b_r <= blk_a_r;
      for (int c = 0; c < 3; c++) begin
        phase_b_r[c] <= fsum[c][F +: 32] + coef[c].ofs + anim_r[c];
      end
      t2_b_r <= tt_r[F +: F];
      gm_b_r <= gm_a_r;
    end
  end

  // ---------------- sine lookups, four stages ----------------
  logic signed [16:0] sine [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_sine
    ipc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
      .clk   (clk),
      .en    (pipe_en),
      .phase (phase_b_r[c]),
      .sine  (sine[c])
    );
  end

  // side band that runs beside the sine lookups
  logic            vld_c_r [1:4];
  logic            blk_c_r [1:4];
  logic [GM_W-1:0] gm_c_r [1:4];
  logic [BM_W-1:0] bm_c_r [1:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= 4; j++) vld_c_r[j] <= 1'b0;
    end else if (pipe_en) begin
      vld_c_r[1] <= vld_b_r;
      for (int j = 2; j <= 4; j++) vld_c_r[j] <= vld_c_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blk_c_r[1] <= blk_b_r;
      gm_c_r[1]  <= gm_b_r;
      bm_c_r[1]  <= BM_W'(t2_b_r) * BM_W'(FIRE_B_GAIN);
      for (int j = 2; j <= 4; j++) begin
        blk_c_r[j] <= blk_c_r[j-1];
        gm_c_r[j]  <= gm_c_r[j-1];
        bm_c_r[j]  <= bm_c_r[j-1];
      end
    end
  end

  // ---------------- stage e: channel products ----------------
  logic [17:0]        lift [0:2];   // 2^17 + sine, always positive
  logic               vld_e_r;
  logic               blk_e_r;
  logic signed [25:0] ov_e_r [0:2];
  logic [FG_W-1:0]    fg_e_r;
  logic [FB_W-1:0]    fb_e_r;

  always_comb begin
    for (int c = 0; c < 3; c++) lift[c] = 18'h20000 + {sine[c][16], sine[c]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_e_r <= 1'b0;
    else if (pipe_en) vld_e_r <= vld_c_r[4];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blk_e_r <= blk_c_r[4];
      for (int c = 0; c < 3; c++) begin
        ov_e_r[c] <= $signed({2'b00, coef[c].base, 16'h0000})
                   + $signed({1'b0, coef[c].amp}) * sine[c];
      end
      fg_e_r <= FG_W'(gm_c_r[4]) * FG_W'(lift[1]);
      fb_e_r <= FB_W'(bm_c_r[4]) * FB_W'(lift[2]);
    end
  end

  // ---------------- output register: shift, clamp and palette mux ----------------
  logic [7:0] oc [0:2];
  logic [7:0] fire_g;
  logic [7:0] fire_b;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] red_r, green_r, blue_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ov_e_r[c][25]) oc[c] = 8'd0;
      else if (ov_e_r[c][25:16] > 10'd255) oc[c] = CHAN_FULL;
      else oc[c] = ov_e_r[c][23:16];
    end
    fire_g = (fg_e_r[FG_W-1:F+17] > 9'd255) ? CHAN_FULL : fg_e_r[F+24:F+17];
    fire_b = fb_e_r[F+24:F+17];
    case (palette_r)
      PAL_BLUE: begin
        red_nxt = oc[0]; green_nxt = oc[1]; blue_nxt = oc[2];
      end
      PAL_FIRE: begin
        red_nxt = CHAN_FULL; green_nxt = fire_g; blue_nxt = fire_b;
      end
      default: begin
        red_nxt = oc[0]; green_nxt = oc[0]; blue_nxt = CHAN_FULL;
      end
    endcase
    if (blk_e_r) begin
      red_nxt = 8'd0; green_nxt = 8'd0; blue_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (pipe_en) out_vld_r <= vld_e_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.red   = red_r;
  assign out_if.green = green_r;
  assign out_if.blue  = blue_r;
  assign out_if.alpha = CHAN_FULL;

  // ---------------- checks ----------------
  // a word parked in the skid stays until the pipeline moves
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !pipe_en |=> skid_vld_r)
    else $error("skid word lost while stalled");

  // an accepted word that cannot enter goes to the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !pipe_en |=> skid_vld_r)
    else $error("stalled input word not parked");

  // the last stage always lands in the output register when it moves
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    vld_e_r && pipe_en |=> out_vld_r)
    else $error("pixel dropped at output register");

  // a black pixel reaches the output as black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    vld_e_r && blk_e_r && pipe_en |=> red_r == 8'd0 && green_r == 8'd0 && blue_r == 8'd0)
    else $error("count at limit not black");

endmodule

@@ hdl/ipc_sine.sv @@
// pipelined quarter-wave sine lookup, four register stages
module ipc_sine import ipc_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [16:0] sine
);

  localparam int D = SINE_TABLE_DEPTH;
  localparam int IW = $clog2(4 * D);
  localparam int AW = $clog2(D + 1);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  typedef logic [15:0] rom_arr_t [0:D];
  typedef longint unsigned div_arr_t [1:7];
  localparam div_arr_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                      64'd210};

  function automatic logic [15:0] rom_entry(input longint unsigned k);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint sum;
    longint unsigned v;
    a = (k * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    a2 = (a * a) >> 30;
    term = a;
    sum = longint'(a);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) * 64'd65535 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int k = 0; k <= D; k++) r[k] = rom_entry(longint'(k));
    return r;
  endfunction

  localparam rom_arr_t SINE_ROM = build_rom();

  logic [63:0]   scaled;
  logic [IW-1:0] idx_r;
  logic [1:0]    quad;
  logic [IW-1:0] kfull;
  logic [AW-1:0] kval;
  logic [AW-1:0] addr_r;
  logic          neg_b_r;
  logic [15:0]   rom_q_r;
  logic          neg_c_r;
  logic signed [16:0] sine_r;

  assign scaled = 64'(phase) * 64'(4 * D);

  always_comb begin
    if (idx_r >= IW'(3 * D)) begin
      quad = 2'd3;
      kfull = idx_r - IW'(3 * D);
    end else if (idx_r >= IW'(2 * D)) begin
      quad = 2'd2;
      kfull = idx_r - IW'(2 * D);
    end else if (idx_r >= IW'(D)) begin
      quad = 2'd1;
      kfull = idx_r - IW'(D);
    end else begin
      quad = 2'd0;
      kfull = idx_r;
    end
    kval = AW'(kfull);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r   <= scaled[32 +: IW];
      addr_r  <= quad[0] ? AW'(D) - kval : kval;
      neg_b_r <= quad[1];
      rom_q_r <= SINE_ROM[addr_r];
      neg_c_r <= neg_b_r;
      sine_r  <= neg_c_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
    end
  end

  assign sine = sine_r;

endmodule
